// ----- src/brf_pkg.sv -----
package brf_pkg;

   // Store geometry and burst limit
   localparam int DEPTH       = 256;
   localparam int MAX_BURST   = 64;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int LEN_W       = 7;
   localparam int BYTE_W      = 8;
   localparam int SUM_W       = CNT_W + 1;
   localparam int CMP_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   // Command queue between front and back, and output word buffer
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int PEND_W      = $clog2(QUEUE_DEPTH + 2);
   localparam int OB_DEPTH    = 2;

   // Command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // One classified command, handed from front to back
   typedef struct packed {
      logic              is_read;
      logic              dropped;
      logic              ovf;
      logic [CNT_W-1:0]  fill;
      logic [LEN_W-1:0]  take;
      logic [ADDR_W-1:0] start;
   } desc_type;

   // One result word waiting at the output
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              byte_valid;
      logic              last;
      logic [CNT_W-1:0]  fill;
      logic              ovf;
      logic              dropped;
   } result_type;

   // Back to front status
   typedef struct packed {
      logic read_done;
   } back_status_type;

   // Ring index advance with wrap at DEPTH
   function automatic logic [ADDR_W-1:0] advance_index(input logic [ADDR_W-1:0] idx);
      logic [ADDR_W-1:0] nxt;
      nxt = (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
      return nxt;
   endfunction

endpackage

// ----- src/brf_ram.sv -----
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/brf_queue.sv -----
module brf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  brf_pkg::desc_type   push_desc,
   input  logic                pop,
   output brf_pkg::desc_type   head_desc,
   output logic                full,
   output logic                empty
);

   brf_pkg::desc_type             slot_ff [brf_pkg::QUEUE_DEPTH];
   logic [brf_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [brf_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [brf_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign full      = (count_ff == brf_pkg::QCNT_W'(brf_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_desc = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == brf_pkg::QPTR_W'(brf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == brf_pkg::QPTR_W'(brf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ----- src/brf_front.sv -----
module brf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [brf_pkg::BYTE_W-1:0]    req_push_byte,
   input  logic [brf_pkg::LEN_W-1:0]     req_read_length,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   output logic                          q_push,
   output brf_pkg::desc_type             q_desc,
   input  logic                          q_full,
   input  brf_pkg::back_status_type      back_status,
   output logic                          ram_wr_en,
   output logic [brf_pkg::ADDR_W-1:0]    ram_wr_addr,
   output logic [brf_pkg::BYTE_W-1:0]    ram_wr_data
);

   logic                          overwrite_ff;
   logic [brf_pkg::ADDR_W-1:0]    head_ff, head_in;
   logic [brf_pkg::ADDR_W-1:0]    tail_ff, tail_in;
   logic [brf_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic [brf_pkg::PEND_W-1:0]    pend_ff, pend_in;

   logic                          accept;
   logic                          drop;
   logic [brf_pkg::ADDR_W-1:0]    tail_next;
   logic                          ovf_push;
   logic [brf_pkg::LEN_W-1:0]     len_sat;
   logic [brf_pkg::CMP_W-1:0]     len_cmp;
   logic [brf_pkg::CMP_W-1:0]     count_cmp;
   logic [brf_pkg::LEN_W-1:0]     take;
   logic [brf_pkg::SUM_W-1:0]     head_sum;

   // A push waits while any read burst still has bytes to fetch
   assign req_stall = q_full || ((req_cmd == brf_pkg::CMD_PUSH) && (pend_ff != '0));
   assign accept    = req_valid && !req_stall;

   // Push classification
   assign drop      = ovf_ff && !overwrite_ff;
   assign tail_next = brf_pkg::advance_index(tail_ff);
   assign ovf_push  = ovf_ff || (head_ff == tail_next);

   // Read length: saturate, then clip to what is stored
   always_comb begin
      len_sat   = (req_read_length > brf_pkg::LEN_W'(brf_pkg::MAX_BURST)) ?
                  brf_pkg::LEN_W'(brf_pkg::MAX_BURST) : req_read_length;
      len_cmp   = brf_pkg::CMP_W'(len_sat);
      count_cmp = brf_pkg::CMP_W'(count_ff);
      take      = (len_cmp > count_cmp) ? brf_pkg::LEN_W'(count_ff) : len_sat;
      head_sum  = brf_pkg::SUM_W'(head_ff) + brf_pkg::SUM_W'(take);
      if (head_sum >= brf_pkg::SUM_W'(brf_pkg::DEPTH)) begin
         head_sum = head_sum - brf_pkg::SUM_W'(brf_pkg::DEPTH);
      end
   end

   // Pointer, count and flag update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_cmd == brf_pkg::CMD_PUSH) begin
            if (!drop) begin
               if (!ovf_ff) begin
                  count_in = count_ff + 1'b1;
               end
               tail_in = tail_next;
               ovf_in  = ovf_push;
               if (ovf_push && overwrite_ff) begin
                  head_in = tail_next;
               end
            end
         end else begin
            head_in  = brf_pkg::ADDR_W'(head_sum);
            count_in = count_ff - brf_pkg::CNT_W'(take);
            if (take != '0) begin
               ovf_in = 1'b0;
            end
         end
      end
   end

   // Outstanding read bursts
   always_comb begin
      pend_in = pend_ff;
      if (accept && (req_cmd == brf_pkg::CMD_READ) && !back_status.read_done) begin
         pend_in = pend_ff + 1'b1;
      end else if (!(accept && (req_cmd == brf_pkg::CMD_READ)) && back_status.read_done) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   // Command word toward the back
   always_comb begin
      q_push         = accept;
      q_desc.is_read = (req_cmd == brf_pkg::CMD_READ);
      q_desc.dropped = (req_cmd == brf_pkg::CMD_PUSH) && drop;
      q_desc.ovf     = ovf_in;
      q_desc.fill    = count_in;
      q_desc.take    = (req_cmd == brf_pkg::CMD_READ) ? take : '0;
      q_desc.start   = head_ff;
   end

   // Store write
   assign ram_wr_en   = accept && (req_cmd == brf_pkg::CMD_PUSH) && !drop;
   assign ram_wr_addr = tail_ff;
   assign ram_wr_data = req_push_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         overwrite_ff <= 1'b1;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            overwrite_ff <= csr_write_data;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ----- src/brf_back.sv -----
module brf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  brf_pkg::desc_type             q_desc,
   input  logic                          q_empty,
   output logic                          q_pop,
   output brf_pkg::back_status_type      back_status,
   output logic                          ram_rd_en,
   output logic [brf_pkg::ADDR_W-1:0]    ram_rd_addr,
   input  logic [brf_pkg::BYTE_W-1:0]    ram_rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brf_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last_of_run,
   output logic [brf_pkg::CNT_W-1:0]     rsp_fill_count,
   output logic                          rsp_overflow_flag,
   output logic                          rsp_byte_dropped
);

   localparam int OB_PTR_W = $clog2(brf_pkg::OB_DEPTH);
   localparam int OB_CNT_W = $clog2(brf_pkg::OB_DEPTH + 1);
   localparam int SPACE_W  = OB_CNT_W + 1;

   // Command in progress
   logic                          cur_valid_ff, cur_valid_in;
   brf_pkg::desc_type             cur_ff, cur_in;
   logic [brf_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [brf_pkg::LEN_W-1:0]     left_ff, left_in;

   // Word waiting on the store read
   logic                          s1_valid_ff;
   brf_pkg::result_type           s1_ff, s1_in;

   // Output word buffer
   brf_pkg::result_type           ob_ff [brf_pkg::OB_DEPTH];
   logic [OB_PTR_W-1:0]           ob_wr_ff, ob_rd_ff;
   logic [OB_CNT_W-1:0]           ob_cnt_ff, ob_cnt_in;

   logic                          pop_out;
   logic                          issue;
   logic                          load;
   logic                          issue_byte;
   logic                          issue_last;
   logic [SPACE_W-1:0]            used;
   brf_pkg::result_type           ob_head;
   brf_pkg::result_type           s1_word;

   assign pop_out = rsp_valid && !rsp_stall;

   // Issue only when the word is sure to find room in the buffer
   assign used       = SPACE_W'(ob_cnt_ff) + SPACE_W'(s1_valid_ff);
   assign issue      = cur_valid_ff &&
                       (used < SPACE_W'(brf_pkg::OB_DEPTH) + SPACE_W'(pop_out));
   assign issue_byte = cur_ff.is_read && (cur_ff.take != '0);
   assign issue_last = !issue_byte || (left_ff == brf_pkg::LEN_W'(1));
   assign load       = !cur_valid_ff && !q_empty;
   assign q_pop      = load;

   assign back_status.read_done = issue && issue_last && cur_ff.is_read;

   assign ram_rd_en   = issue && issue_byte;
   assign ram_rd_addr = addr_ff;

   // Command sequencing
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      if (load) begin
         cur_valid_in = 1'b1;
         cur_in       = q_desc;
         addr_in      = q_desc.start;
         left_in      = q_desc.take;
      end else if (issue) begin
         if (issue_last) begin
            cur_valid_in = 1'b0;
         end else begin
            addr_in = brf_pkg::advance_index(addr_ff);
            left_in = left_ff - 1'b1;
         end
      end
   end

   // Result fields known at issue time
   always_comb begin
      s1_in.data       = '0;
      s1_in.byte_valid = issue_byte;
      s1_in.last       = issue_last;
      s1_in.fill       = cur_ff.fill;
      s1_in.ovf        = cur_ff.ovf;
      s1_in.dropped    = cur_ff.dropped;
   end

   // Merge store data into the waiting word
   always_comb begin
      s1_word      = s1_ff;
      s1_word.data = s1_ff.byte_valid ? ram_rd_data : '0;
   end

   always_comb begin
      ob_cnt_in = ob_cnt_ff;
      if (s1_valid_ff && !pop_out) begin
         ob_cnt_in = ob_cnt_ff + 1'b1;
      end else if (!s1_valid_ff && pop_out) begin
         ob_cnt_in = ob_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         ob_wr_ff     <= '0;
         ob_rd_ff     <= '0;
         ob_cnt_ff    <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         s1_valid_ff  <= issue;
         ob_cnt_ff    <= ob_cnt_in;
         if (s1_valid_ff) begin
            ob_wr_ff <= (ob_wr_ff == OB_PTR_W'(brf_pkg::OB_DEPTH - 1)) ?
                        '0 : ob_wr_ff + 1'b1;
         end
         if (pop_out) begin
            ob_rd_ff <= (ob_rd_ff == OB_PTR_W'(brf_pkg::OB_DEPTH - 1)) ?
                        '0 : ob_rd_ff + 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      addr_ff <= addr_in;
      left_ff <= left_in;
      if (issue) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff) begin
         ob_ff[ob_wr_ff] <= s1_word;
      end
   end

   // Output word
   assign ob_head           = ob_ff[ob_rd_ff];
   assign rsp_valid         = (ob_cnt_ff != '0);
   assign rsp_out_byte      = ob_head.data;
   assign rsp_byte_valid    = ob_head.byte_valid;
   assign rsp_last_of_run   = ob_head.last;
   assign rsp_fill_count    = ob_head.fill;
   assign rsp_overflow_flag = ob_head.ovf;
   assign rsp_byte_dropped  = ob_head.dropped;

endmodule

// ----- src/byte_ring_fifo_overflow_modes.sv -----
// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+-------------------------------------------
// req      | in        | req_valid/req_stall | cmd, push_byte, read_length
// rsp      | out       | rsp_valid/rsp_stall | out_byte, byte_valid, last_of_run, fill,
//          |           |                     | overflow_flag, byte_dropped
// csr      | in        | csr_write_enable    | overwrite_oldest
//
// A push is handled in the front and gives one word. A read burst gives one word per
// cycle from the store's single read port while rsp is not stalled, once the back has
// loaded the command; a push stalls until earlier reads have fetched all their bytes.
// Reset is synchronous and needs no clearing pass; the byte store is never read where
// it was not written. Stalls on rsp back up through a two-word output buffer and a
// two-entry command queue into req_stall.
module byte_ring_fifo_overflow_modes (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [brf_pkg::BYTE_W-1:0]    req_push_byte,
   input  logic [brf_pkg::LEN_W-1:0]     req_read_length,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brf_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last_of_run,
   output logic [brf_pkg::CNT_W-1:0]     rsp_fill_count,
   output logic                          rsp_overflow_flag,
   output logic                          rsp_byte_dropped
);

   logic                          q_push;
   logic                          q_pop;
   logic                          q_full;
   logic                          q_empty;
   brf_pkg::desc_type             q_in_desc;
   brf_pkg::desc_type             q_out_desc;
   brf_pkg::back_status_type      back_status;
   logic                          ram_wr_en;
   logic [brf_pkg::ADDR_W-1:0]    ram_wr_addr;
   logic [brf_pkg::BYTE_W-1:0]    ram_wr_data;
   logic                          ram_rd_en;
   logic [brf_pkg::ADDR_W-1:0]    ram_rd_addr;
   logic [brf_pkg::BYTE_W-1:0]    ram_rd_data;

   // Front: accepts, classifies, owns the pointers
   brf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_push_byte    (req_push_byte),
      .req_read_length  (req_read_length),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_push           (q_push),
      .q_desc           (q_in_desc),
      .q_full           (q_full),
      .back_status      (back_status),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data)
   );

   // Command queue
   brf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_in_desc),
      .pop       (q_pop),
      .head_desc (q_out_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Byte store
   brf_ram #(
      .WIDTH (brf_pkg::BYTE_W),
      .DEPTH (brf_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Back: emits result words
   brf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_desc            (q_out_desc),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .back_status       (back_status),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_byte_dropped  (rsp_byte_dropped)
   );

endmodule

// ----- src/brf_checker.sv -----
module brf_port_checks (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [brf_pkg::BYTE_W-1:0]    rsp_out_byte,
   input logic                          rsp_byte_valid,
   input logic                          rsp_last_of_run,
   input logic [brf_pkg::CNT_W-1:0]     rsp_fill_count,
   input logic                          rsp_overflow_flag,
   input logic                          rsp_byte_dropped
);

   // A word with no byte carries zero and closes its run
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> (rsp_out_byte == '0) && rsp_last_of_run)
      else $error("word without byte is not zero or not last");

   // Overflow only with a full store
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_flag |->
         rsp_fill_count == brf_pkg::CNT_W'(brf_pkg::DEPTH))
      else $error("overflow flag with store not full");

   // Popped bytes never report a drop or overflow
   a_pop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_byte_dropped && !rsp_overflow_flag)
      else $error("popped byte marked dropped or overflowed");

   // Stalled word holds its byte, last flag and fill count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_last_of_run) && $stable(rsp_fill_count))
      else $error("stalled result word changed");

endmodule

bind byte_ring_fifo_overflow_modes brf_port_checks u_brf_port_checks (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_byte_valid    (rsp_byte_valid),
   .rsp_last_of_run   (rsp_last_of_run),
   .rsp_fill_count    (rsp_fill_count),
   .rsp_overflow_flag (rsp_overflow_flag),
   .rsp_byte_dropped  (rsp_byte_dropped)
);
